>>> sv/axis_angle_vector_rotate_top_defines.svh
// ----------------------------------------------------------------------------
// Axis-angle rotate assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_VECTOR_ROTATE_TOP_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_TOP_DEFINES_SVH

// same-cycle implication
`define AAVR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AAVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/aavr_pkg.sv
// ----------------------------------------------------------------------------
// Axis-angle rotate package
// Fixed-point types, polynomial coefficients and phase constants.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int TRIG_ONE     = 65536;
  localparam int ANGLE_BITS   = 16;
  localparam int PHASE_DROP   = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
  localparam int HORNER_STEPS = 4;

  typedef logic signed [33:0] poly_t;

  localparam poly_t COEF_START = 34'sd172272;
  localparam poly_t HORNER_COEF [HORNER_STEPS] = '{
    -34'sd5026995, 34'sd85569306, -34'sd693598669, 34'sd1686629713
  };

  // one sine evaluation in flight: argument, its square, running polynomial
  typedef struct packed {
    logic [16:0] u;
    logic [16:0] u2;
    poly_t       p;
  } lane_t;

  // vector terms waiting for sine and cosine
  typedef struct packed {
    logic [2:0][31:0]   coord;
    logic [2:0][15:0]   axis;
    logic signed [35:0] d;
    logic [2:0][35:0]   cr;
  } vec_t;

endpackage

>>> sv/aavr_horner_cell.sv
// ----------------------------------------------------------------------------
// Horner cell
// One polynomial step p = coef + ((p * u2) >>> 16), registered.
// ----------------------------------------------------------------------------
module aavr_horner_cell (
  input  logic            clk,
  input  logic            en,
  input  aavr_pkg::poly_t coef,
  input  aavr_pkg::lane_t lane_in,
  output aavr_pkg::lane_t lane_out
);

  logic signed [51:0] prod;
  logic signed [51:0] acc;

  assign prod = $signed(lane_in.p) * $signed({1'b0, lane_in.u2});
  assign acc  = (prod >>> 16) + 52'(coef);

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out.u  <= lane_in.u;
      lane_out.u2 <= lane_in.u2;
      lane_out.p  <= acc[33:0];
    end
  end

endmodule

>>> sv/axis_angle_vector_rotate_top.sv
// ----------------------------------------------------------------------------
// Axis-angle vector rotate
// Rotates a Q15.16 coordinate about a Q1.14 axis by Rodrigues' formula.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one word per clock while out_stall
// is low (nine register stages). Sine and cosine come from two rows of
// four Horner cells, one per polynomial step, running beside the vector
// products; the vector terms ride a delay line until the trig values arrive.
// The whole pipeline moves as one: when a finished word is stalled at the
// output, in_stall rises and every stage holds. The axis is not normalized
// and results saturate to the signed 32-bit range.
module axis_angle_vector_rotate_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] turns,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  localparam int STAGES = 9;
  localparam int HS     = aavr_pkg::HORNER_STEPS;

  typedef enum logic [1:0] {
    QUAD0 = 2'd0,
    QUAD1 = 2'd1,
    QUAD2 = 2'd2,
    QUAD3 = 2'd3
  } quad_t;

  logic [STAGES-1:0] vld;
  logic              en;

  assign en        = !(vld[STAGES-1] && out_stall);
  assign in_stall  = vld[STAGES-1] && out_stall;
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // stage 1: phase, squares, vector products
  logic [15:0]        u_a;
  logic [16:0]        u_b;
  logic [31:0]        sq_a;
  logic [33:0]        sq_b;
  logic signed [15:0] ax [3];
  logic signed [31:0] cx [3];

  assign u_a  = {turns[13:0], 2'b00} & (16'hFFFF << (aavr_pkg::PHASE_DROP + 2));
  assign u_b  = 17'(aavr_pkg::TRIG_ONE) - {1'b0, u_a};
  assign sq_a = u_a * u_a;
  assign sq_b = u_b * u_b;
  assign ax[0] = axis_x;
  assign ax[1] = axis_y;
  assign ax[2] = axis_z;
  assign cx[0] = coord_x;
  assign cx[1] = coord_y;
  assign cx[2] = coord_z;

  aavr_pkg::lane_t    lane_a [HS+1];
  aavr_pkg::lane_t    lane_b [HS+1];
  quad_t              q_pipe [HS+1];
  logic signed [47:0] pr [3][3];
  logic signed [15:0] ax_r [3];
  logic signed [31:0] cx_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      lane_a[0].u  <= {1'b0, u_a};
      lane_a[0].u2 <= {1'b0, sq_a[31:16]};
      lane_a[0].p  <= aavr_pkg::COEF_START;
      lane_b[0].u  <= u_b;
      lane_b[0].u2 <= sq_b[32:16];
      lane_b[0].p  <= aavr_pkg::COEF_START;
      q_pipe[0]    <= quad_t'(turns[15:14]);
      for (int i = 1; i <= HS; i++) begin
        q_pipe[i] <= q_pipe[i-1];
      end
      for (int i = 0; i < 3; i++) begin
        ax_r[i] <= ax[i];
        cx_r[i] <= cx[i];
        for (int j = 0; j < 3; j++) begin
          pr[i][j] <= ax[i] * cx[j];
        end
      end
    end
  end

  // stages 2 to 5: polynomial cells for S(u) and S(1-u)
  for (genvar k = 0; k < HS; k++) begin : g_cell
    aavr_horner_cell u_cell_a (
      .clk      (clk),
      .en       (en),
      .coef     (aavr_pkg::HORNER_COEF[k]),
      .lane_in  (lane_a[k]),
      .lane_out (lane_a[k+1])
    );
    aavr_horner_cell u_cell_b (
      .clk      (clk),
      .en       (en),
      .coef     (aavr_pkg::HORNER_COEF[k]),
      .lane_in  (lane_b[k]),
      .lane_out (lane_b[k+1])
    );
  end

  // stage 2: dot and cross, then delay to meet the trig values
  logic signed [49:0] dot_sum;
  logic signed [49:0] cr_diff [3];
  aavr_pkg::vec_t     vec_in;
  aavr_pkg::vec_t     vec_pipe [HS+1];

  always_comb begin
    dot_sum    = 50'(pr[0][0]) + 50'(pr[1][1]) + 50'(pr[2][2]);
    cr_diff[0] = 50'(pr[1][2]) - 50'(pr[2][1]);
    cr_diff[1] = 50'(pr[2][0]) - 50'(pr[0][2]);
    cr_diff[2] = 50'(pr[0][1]) - 50'(pr[1][0]);
    vec_in.d   = 36'(dot_sum >>> 14);
    for (int i = 0; i < 3; i++) begin
      vec_in.coord[i] = cx_r[i];
      vec_in.axis[i]  = ax_r[i];
      vec_in.cr[i]    = 36'(cr_diff[i] >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_pipe[0] <= vec_in;
      for (int i = 1; i <= HS; i++) begin
        vec_pipe[i] <= vec_pipe[i-1];
      end
    end
  end

  // stage 6: final scale, clamp, quadrant fold
  logic signed [51:0] fin_a;
  logic signed [51:0] fin_b;
  logic signed [51:0] sh_a;
  logic signed [51:0] sh_b;
  logic signed [17:0] sa;
  logic signed [17:0] sb;
  logic signed [17:0] s_next;
  logic signed [17:0] c_next;
  logic signed [17:0] s_r;
  logic signed [17:0] c_r;

  assign fin_a = $signed(lane_a[HS].p) * $signed({1'b0, lane_a[HS].u});
  assign fin_b = $signed(lane_b[HS].p) * $signed({1'b0, lane_b[HS].u});
  assign sh_a  = fin_a >>> 30;
  assign sh_b  = fin_b >>> 30;

  always_comb begin
    if (sh_a < 0) begin
      sa = '0;
    end else if (sh_a > 52'sd65536) begin
      sa = 18'sd65536;
    end else begin
      sa = sh_a[17:0];
    end
    if (sh_b < 0) begin
      sb = '0;
    end else if (sh_b > 52'sd65536) begin
      sb = 18'sd65536;
    end else begin
      sb = sh_b[17:0];
    end
    case (q_pipe[HS])
      QUAD0: begin
        s_next = sa;
        c_next = sb;
      end
      QUAD1: begin
        s_next = sb;
        c_next = -sa;
      end
      QUAD2: begin
        s_next = -sa;
        c_next = -sb;
      end
      default: begin
        s_next = -sb;
        c_next = sa;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_next;
      c_r <= c_next;
    end
  end

  // stage 7: cosine, cross and dot scaling
  aavr_pkg::vec_t     vs;
  logic signed [18:0] omc;
  logic signed [54:0] t_prod;
  logic signed [49:0] xc_prod [3];
  logic signed [53:0] cs_prod [3];
  logic signed [39:0] t_r;
  logic signed [39:0] xc_r [3];
  logic signed [39:0] cs_r [3];
  logic signed [15:0] n7_r [3];

  assign vs     = vec_pipe[HS];
  assign omc    = 19'(aavr_pkg::TRIG_ONE) - 19'(c_r);
  assign t_prod = vs.d * omc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xc_prod[i] = $signed(vs.coord[i]) * c_r;
      cs_prod[i] = $signed(vs.cr[i]) * s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= 40'(t_prod >>> 16);
      for (int i = 0; i < 3; i++) begin
        xc_r[i] <= 40'(xc_prod[i] >>> 16);
        cs_r[i] <= 40'(cs_prod[i] >>> 16);
        n7_r[i] <= $signed(vs.axis[i]);
      end
    end
  end

  // stage 8: parallel part per axis
  logic signed [55:0] tn_prod [3];
  logic signed [43:0] tn_r [3];
  logic signed [43:0] sum1_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tn_prod[i] = t_r * n7_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tn_r[i]   <= 44'(tn_prod[i] >>> 14);
        sum1_r[i] <= 44'(xc_r[i]) + 44'(cs_r[i]);
      end
    end
  end

  // stage 9: add and saturate into the output word
  logic signed [43:0] v   [3];
  logic signed [31:0] sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v[i] = sum1_r[i] + tn_r[i];
      if (v[i] > 44'sd2147483647) begin
        sat[i] = 32'sh7FFFFFFF;
      end else if (v[i] < -44'sd2147483648) begin
        sat[i] = 32'sh80000000;
      end else begin
        sat[i] = v[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= sat[0];
      out_y <= sat[1];
      out_z <= sat[2];
    end
  end

  logic trig_ok;

  assign trig_ok = (s_r <= 18'sd65536) && (s_r >= -18'sd65536) &&
                   (c_r <= 18'sd65536) && (c_r >= -18'sd65536);

`include "axis_angle_vector_rotate_top_defines.svh"

  `AAVR_ASSERT_NOW(a_stall_back, out_valid && out_stall, in_stall, "output stall not passed back")
  `AAVR_ASSERT_NEXT(a_take, in_valid && !in_stall, vld[0], "accepted word not in pipeline")
  `AAVR_ASSERT_NOW(a_trig_range, vld[5], trig_ok, "trig value out of range")

endmodule

>>> tb/tb_axis_angle_vector_rotate_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Axis-angle rotate testbench
// Drives coordinate/axis/angle words with random gaps, stalls the output at
// random and against a long hold-off, and checks every rotated word against
// an in-bench fixed-point Rodrigues predictor.
// ----------------------------------------------------------------------------
module tb_axis_angle_vector_rotate_top;

  typedef struct packed {
    logic signed [15:0] turns;
    logic signed [15:0] ax, ay, az;
    logic signed [31:0] cx, cy, cz;
  } rot_req_t;

  typedef struct packed {
    logic signed [31:0] x, y, z;
  } rot_vec_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] turns = '0, axis_x = '0, axis_y = '0, axis_z = '0;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;

  rot_req_t pending_words[$];
  rot_vec_t rotated_expect[$];
  int       fail_cnt = 0;
  bit       stim_done = 1'b0;
  bit       calm = 1'b0;
  bit       in_taken = 1'b0;
  int       holdoff = 0;
  int       out_cyc = 0;

  axis_angle_vector_rotate_top u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sine_q16(longint u);
    longint u2, p, r;
    u2 = (u * u) >>> 16;
    p = 172272;
    p = -64'sd5026995 + ((p * u2) >>> 16);
    p = 64'sd85569306 + ((p * u2) >>> 16);
    p = -64'sd693598669 + ((p * u2) >>> 16);
    p = 64'sd1686629713 + ((p * u2) >>> 16);
    r = (p * u) >>> 30;
    if (r < 0) r = 0;
    if (r > 65536) r = 65536;
    return r;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic rot_vec_t rotate_about_axis(rot_req_t w);
    logic [15:0] ph;
    longint u, a, b, s, c, d, t, v;
    longint n[3], x[3], cr[3];
    rot_vec_t res;
    ph = w.turns;
    u = longint'(ph[13:0]) << 2;
    a = sine_q16(u);
    b = sine_q16(65536 - u);
    case (ph[15:14])
      2'd0: begin s = a;  c = b;  end
      2'd1: begin s = b;  c = -a; end
      2'd2: begin s = -a; c = -b; end
      default: begin s = -b; c = a; end
    endcase
    n[0] = w.ax; n[1] = w.ay; n[2] = w.az;
    x[0] = w.cx; x[1] = w.cy; x[2] = w.cz;
    d = (n[0] * x[0] + n[1] * x[1] + n[2] * x[2]) >>> 14;
    t = (d * (65536 - c)) >>> 16;
    cr[0] = (n[1] * x[2] - n[2] * x[1]) >>> 14;
    cr[1] = (n[2] * x[0] - n[0] * x[2]) >>> 14;
    cr[2] = (n[0] * x[1] - n[1] * x[0]) >>> 14;
    v = clamp32(((x[0] * c) >>> 16) + ((t * n[0]) >>> 14) + ((cr[0] * s) >>> 16));
    res.x = v[31:0];
    v = clamp32(((x[1] * c) >>> 16) + ((t * n[1]) >>> 14) + ((cr[1] * s) >>> 16));
    res.y = v[31:0];
    v = clamp32(((x[2] * c) >>> 16) + ((t * n[2]) >>> 14) + ((cr[2] * s) >>> 16));
    res.z = v[31:0];
    return res;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0: return 16'sh4000;
      1: return -16'sh4000;
      2: return 16'h8000;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  // directed words then random
  initial begin
    rot_req_t w;
    logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                             16'h7fff, 16'h0001, 16'hffff, 16'h2000};
    foreach (angs[i]) begin
      w = '{angs[i], 16'sh4000, 16'sh0, 16'sh0, 32'sh10000, 32'sh20000, -32'sh30000};
      pending_words.push_back(w);
      w = '{angs[i], 16'sh0, 16'sh0, 16'sh4000, 32'sh7fffffff, 32'sh7fffffff,
            32'sh80000000};
      pending_words.push_back(w);
    end
    pending_words.push_back('{16'h1234, 16'h8000, 16'h8000, 16'h8000,
                              32'sh80000000, 32'sh80000000, 32'sh80000000});
    pending_words.push_back('{16'h5555, 16'h7fff, 16'h7fff, 16'h7fff,
                              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
    pending_words.push_back('{16'h0003, 16'sh2d41, 16'sh2d41, 16'sh0,
                              32'sh0, 32'sh0, 32'sh0});
    pending_words.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff,
                              32'hffffffff, 32'hffffffff, 32'hffffffff});
    for (int i = 0; i < 1550; i++) begin
      w.turns = 16'($urandom);
      w.ax = rand_axis(); w.ay = rand_axis(); w.az = rand_axis();
      w.cx = rand_coord(); w.cy = rand_coord(); w.cz = rand_coord();
      pending_words.push_back(w);
    end
  end

  // note whether the offered word was taken at this edge
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
        rot_req_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        turns <= w.turns; axis_x <= w.ax; axis_y <= w.ay; axis_z <= w.az;
        coord_x <= w.cx; coord_y <= w.cy; coord_z <= w.cz;
        rotated_expect.push_back(rotate_about_axis(w));
      end else begin
        in_valid <= 1'b0;
        if (pending_words.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // receiver stall: long hold-off once, a calm stretch, otherwise random
  always @(negedge clk) begin
    if (!rst) begin
      out_cyc <= out_cyc + 1;
      calm <= (out_cyc >= 400 && out_cyc < 800);
      if (out_cyc == 1000) holdoff <= 200;
      else if (holdoff != 0) holdoff <= holdoff - 1;
      out_stall <= (holdoff > 1) || (out_cyc == 1000) ||
                   (!calm && $urandom_range(0, 99) < 23);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (rotated_expect.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h z=%h", $time, out_x, out_y, out_z);
        fail_cnt <= fail_cnt + 1;
      end else begin
        rot_vec_t e;
        e = rotated_expect.pop_front();
        if (e.x !== out_x || e.y !== out_y || e.z !== out_z) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h actual x=%h y=%h z=%h",
                   $time, e.x, e.y, e.z, out_x, out_y, out_z);
          fail_cnt <= fail_cnt + 1;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && rotated_expect.size() == 0);
    repeat (30) @(posedge clk);
    if (fail_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
